@@ sv/swp_pkg.sv @@
// shared types and constants for the spike waveform packetizer
`default_nettype none

package swp_pkg;

    // field widths
    localparam int CHAN_W   = 8;
    localparam int GROUP_W  = 8;
    localparam int SIDX_W   = 6;
    localparam int HALF_W   = 64;
    localparam int TS_W     = 32;
    localparam int MTIME_W  = 16;

    // slave tdata layout, lowest field first
    localparam int S_CHAN_LSB  = 0;
    localparam int S_GROUP_LSB = S_CHAN_LSB + CHAN_W;
    localparam int S_SIDX_LSB  = S_GROUP_LSB + GROUP_W;
    localparam int S_LOW_LSB   = S_SIDX_LSB + SIDX_W;
    localparam int S_HIGH_LSB  = S_LOW_LSB + HALF_W;
    localparam int S_TS_LSB    = S_HIGH_LSB + HALF_W;
    localparam int S_USED_W    = S_TS_LSB + TS_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    localparam int M_TDATA_W   = 2 * HALF_W;

    localparam logic [MTIME_W-1:0] MIN_TIME_RESET = 16'd10;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HEAD = 3'b010,
        ST_WORD = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;    // input beat taken this cycle
        logic load_head;  // put header into output register
        logic rd_first;   // read first stored sample
        logic load_word;  // put read sample into output register
        logic rd_next;    // read following stored sample
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;       // current input beat triggers a packet
        logic out_free;   // output register can take a word
        logic last_idx;   // sample being read is the final one
    } stat_t;

endpackage

`default_nettype wire

@@ sv/swp_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module swp_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [ADDR_W-1:0]       raddr,
    output      logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/swp_ctrl.sv @@
// packet sequencer state machine
`default_nettype none

module swp_ctrl
    import swp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output      logic  s_tready,
    input  wire stat_t stat,
    output      cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.emit)
                    begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_head = 1'b1;
                    cmd.rd_first  = 1'b1;
                    state_next    = ST_WORD;
                end
            end
            ST_WORD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_word = 1'b1;
                    if (stat.last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/swp_dp.sv @@
// sample store, header capture and output register
`default_nettype none

module swp_dp
    import swp_pkg::*;
#(
    parameter int CHANNELS  = 160,
    parameter int SPIKE_LEN = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    input  wire logic                 min_time_we,
    input  wire logic [MTIME_W-1:0]   min_time_wdata,
    input  wire logic                 m_tready,
    output      logic                 m_tvalid,
    output      logic [M_TDATA_W-1:0] m_tdata,
    output      logic                 m_tlast,
    input  wire cmd_t                 cmd,
    output      stat_t                stat
);
    localparam int DEPTH  = 2 * CHANNELS * SPIKE_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (SPIKE_LEN > 1) ? $clog2(SPIKE_LEN) : 1;

    // input fields
    logic [CHAN_W-1:0]  in_chan;
    logic [GROUP_W-1:0] in_group;
    logic [SIDX_W-1:0]  in_sidx;
    logic [HALF_W-1:0]  in_low;
    logic [HALF_W-1:0]  in_high;
    logic [TS_W-1:0]    in_ts;
    logic [TS_W-1:0]    in_t;
    logic               in_chan_ok;
    logic               in_sidx_ok;
    logic [ADDR_W-1:0]  in_base;
    logic [ADDR_W-1:0]  waddr;
    logic               wr_en;

    logic [MTIME_W-1:0] min_time_reg;

    logic [TS_W-1:0]    hdr_t_reg;
    logic [GROUP_W-1:0] hdr_group_reg;
    logic [CHAN_W-1:0]  hdr_chan_reg;
    logic               hdr_ok_reg;
    logic [ADDR_W-1:0]  base_reg;

    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]  raddr;
    logic               rd_en;
    logic [HALF_W-1:0]  rd_low;
    logic [HALF_W-1:0]  rd_high;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    assign in_chan  = s_tdata[S_CHAN_LSB +: CHAN_W];
    assign in_group = s_tdata[S_GROUP_LSB +: GROUP_W];
    assign in_sidx  = s_tdata[S_SIDX_LSB +: SIDX_W];
    assign in_low   = s_tdata[S_LOW_LSB +: HALF_W];
    assign in_high  = s_tdata[S_HIGH_LSB +: HALF_W];
    assign in_ts    = s_tdata[S_TS_LSB +: TS_W];
    assign in_t     = in_ts - TS_W'(1);

    assign in_chan_ok = {1'b0, in_chan} < (CHAN_W + 1)'(CHANNELS);
    assign in_sidx_ok = {1'b0, in_sidx} < (SIDX_W + 1)'(SPIKE_LEN);
    assign in_base    = ADDR_W'((32'(s_tuser) * CHANNELS + 32'(in_chan)) * SPIKE_LEN);
    assign waddr      = in_base + ADDR_W'(in_sidx);
    assign wr_en      = cmd.capture && in_chan_ok && in_sidx_ok;

    // signed t greater than zero-extended min_time
    assign stat.emit = s_tlast && !in_t[TS_W-1]
                    && (in_t[TS_W-2:0] > (TS_W - 1)'(min_time_reg));
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last_idx = rd_idx_reg == IDX_W'(SPIKE_LEN - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg <= MIN_TIME_RESET;
        end
        else if (min_time_we)
        begin
            min_time_reg <= min_time_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hdr_t_reg     <= in_t;
            hdr_group_reg <= in_group;
            hdr_chan_reg  <= in_chan;
            hdr_ok_reg    <= in_chan_ok;
            base_reg      <= in_base;
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_first)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
    end

    assign rd_en = (cmd.rd_first || cmd.rd_next) && hdr_ok_reg;
    assign raddr = base_reg + ADDR_W'(rd_idx_next);

    swp_ram #(
        .WIDTH (HALF_W),
        .DEPTH (DEPTH)
    ) u_ram_low (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (in_low),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_low)
    );

    swp_ram #(
        .WIDTH (HALF_W),
        .DEPTH (DEPTH)
    ) u_ram_high (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (in_high),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_high)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (cmd.load_head)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(HALF_W - CHAN_W){1'b0}}, hdr_chan_reg,
                              hdr_t_reg, {(HALF_W - TS_W - GROUP_W){1'b0}}, hdr_group_reg};
            out_last_next  = 1'b0;
        end
        else if (cmd.load_word)
        begin
            out_valid_next = 1'b1;
            out_data_next  = hdr_ok_reg ? {rd_high, rd_low} : '0;
            out_last_next  = stat.last_idx;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ sv/spike_waveform_packetizer.sv @@
// top level of the spike waveform packetizer
`default_nettype none

// Stores 128-bit spike sample words per channel in two banks and sends a
// packet when a spike ends. Every slave beat writes its sample (channel,
// bank, sample_index). A beat with tlast set finishes the spike: t =
// timestamp - 1 is compared signed against min_time and, if greater, a
// packet of SPIKE_LEN + 1 master beats follows: a header word (low half
// {t, group}, high half channel) and then every stored sample of that
// channel and bank, the final one marked with tlast. The packet leaves at
// one beat a cycle while the master side is ready; the slave side is held
// off from the finishing beat until the final word is in the output
// register: the header is loaded first, then each sample is read in turn
// through the single read port of the sample store. A finished word waits
// in the output register so the next slave beat can be taken meanwhile.
// Samples never written read back as garbage; writes to a channel at or
// above CHANNELS or an index at or above SPIKE_LEN are dropped, and
// packets for such a channel carry zero samples.
// The store needs no clearing after reset.
module spike_waveform_packetizer
    import swp_pkg::*;
#(
    parameter int CHANNELS  = 160,
    parameter int SPIKE_LEN = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config
    input  wire logic                 min_time_we,
    input  wire logic [MTIME_W-1:0]   min_time_wdata,
    // slave side
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // channel[7:0], group[15:8], sample_index[21:16], sample_low[85:22],
    // sample_high[149:86], timestamp[181:150], zero fill[183:182]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // bank[0]
    input  wire logic                 s_tuser,
    // finish
    input  wire logic                 s_tlast,
    // master side
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // word_low[63:0], word_high[127:64]
    output      logic [M_TDATA_W-1:0] m_tdata,
    // last_word
    output      logic                 m_tlast
);
    cmd_t  cmd;
    stat_t stat;

    // sequencer: idle / header / sample readout
    swp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, threshold compare and output register
    swp_dp #(
        .CHANNELS  (CHANNELS),
        .SPIKE_LEN (SPIKE_LEN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .min_time_we    (min_time_we),
        .min_time_wdata (min_time_wdata),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire

@@ sv/swp_checker.sv @@
// port level checks for the spike waveform packetizer and their bind
`default_nettype none

module swp_checker
    import swp_pkg::*;
#(
    parameter int SPIKE_LEN = 32
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 min_time_we,
    input wire logic [MTIME_W-1:0]   min_time_wdata,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 s_tlast,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);
    localparam int CNT_W = $clog2(SPIKE_LEN + 2);

    logic [MTIME_W-1:0] min_time_reg;
    logic [CNT_W-1:0]   beat_cnt_reg;
    logic [TS_W-1:0]    t_val;
    logic               trigger;
    logic               m_beat;

    assign t_val   = s_tdata[S_TS_LSB +: TS_W] - TS_W'(1);
    assign trigger = s_tvalid && s_tready && s_tlast && !t_val[TS_W-1]
                  && (t_val[TS_W-2:0] > (TS_W - 1)'(min_time_reg));
    assign m_beat  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg <= MIN_TIME_RESET;
            beat_cnt_reg <= '0;
        end
        else
        begin
            if (min_time_we)
            begin
                min_time_reg <= min_time_wdata;
            end
            if (m_beat)
            begin
                beat_cnt_reg <= m_tlast ? '0 : beat_cnt_reg + CNT_W'(1);
            end
        end
    end

    // stalled master beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("master beat changed while stalled");

    // first beat of a packet is a header with zero upper bits
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (beat_cnt_reg == '0) |-> (m_tdata[M_TDATA_W-1:HALF_W+CHAN_W] == '0))
        else $error("header word has nonzero upper bits");

    // tlast marks exactly the final word of a packet
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat |-> (m_tlast == (beat_cnt_reg == CNT_W'(SPIKE_LEN))))
        else $error("tlast on wrong beat");

    // a finishing beat over threshold holds off the slave side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        trigger |=> !s_tready)
        else $error("slave side not held during packet");

endmodule

bind spike_waveform_packetizer swp_checker #(
    .SPIKE_LEN (SPIKE_LEN)
) u_swp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_time_we    (min_time_we),
    .min_time_wdata (min_time_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
);

`default_nettype wire

@@ bench/spike_waveform_packetizer_test.sv @@
// self-checking testbench for the spike waveform packetizer
`timescale 1ns / 100ps

module spike_waveform_packetizer_test;
    import swp_pkg::*;

    localparam int CHANNELS     = 160;
    localparam int SPIKE_LEN    = 32;
    localparam int HOLD_CYCLES  = 400;          // long output stall for back-pressure
    localparam int DRAIN_CYCLES = SPIKE_LEN + 8; // block latency margin after the last word
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_BEATS  = 80;
    localparam int PHASES       = 5;
    localparam int MAX_REPORTS  = 10;
    localparam int GAP_MAX      = 18;
    localparam int POOL_SIZE    = 6;

    // one input beat, unpacked into its fields
    typedef struct packed {
        bit [CHAN_W-1:0]  chan;
        bit [GROUP_W-1:0] grp;
        bit               bank;
        bit [SIDX_W-1:0]  sidx;
        bit [HALF_W-1:0]  lo;
        bit [HALF_W-1:0]  hi;
        bit               finish;
        bit [TS_W-1:0]    ts;
    } spike_beat_t;

    // one output beat of a packet
    typedef struct packed {
        bit [HALF_W-1:0] lo;
        bit [HALF_W-1:0] hi;
        bit              last;
    } packet_word_t;

    // mirrors the waveform store and predicts the packet words of each beat
    class packet_predictor;
        bit [HALF_W-1:0]  lo_store [2][CHANNELS][SPIKE_LEN];
        bit [HALF_W-1:0]  hi_store [2][CHANNELS][SPIKE_LEN];
        bit [MTIME_W-1:0] min_time;
        packet_word_t     expected_words [$];
        int               failures;
        int               packets;
        int               words_seen;

        function new();
            min_time   = MIN_TIME_RESET;
            failures   = 0;
            packets    = 0;
            words_seen = 0;
        endfunction

        // t = timestamp - 1, wrapping in 32 bits, compared signed
        function bit would_emit(bit [TS_W-1:0] ts);
            bit signed [TS_W-1:0] t;
            t = ts - 1'b1;
            return t > $signed({{(TS_W-MTIME_W){1'b0}}, min_time});
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // accepted input beat: store the sample first, then queue the packet if due
        function void take_beat(spike_beat_t b);
            bit [TS_W-1:0] t;
            packet_word_t  w;
            bit            chan_ok;
            int            j;
            chan_ok = b.chan < CHANNELS;
            if (chan_ok && b.sidx < SPIKE_LEN)
            begin
                lo_store[b.bank][b.chan][b.sidx] = b.lo;
                hi_store[b.bank][b.chan][b.sidx] = b.hi;
            end
            if (!b.finish || !would_emit(b.ts))
                return;
            t      = b.ts - 1'b1;
            w.lo   = {t, 24'd0, b.grp};
            w.hi   = {56'd0, b.chan};
            w.last = 1'b0;
            expected_words.push_back(w);
            for (j = 0; j < SPIKE_LEN; j++)
            begin
                // channels out of range carry zero samples
                w.lo   = chan_ok ? lo_store[b.bank][b.chan][j] : '0;
                w.hi   = chan_ok ? hi_store[b.bank][b.chan][j] : '0;
                w.last = (j == SPIKE_LEN - 1);
                expected_words.push_back(w);
            end
            packets++;
        endfunction

        // accepted output beat against the oldest queued word
        function void check_word(bit [HALF_W-1:0] lo, bit [HALF_W-1:0] hi, bit last);
            packet_word_t w;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                flag($sformatf("unexpected word: lo=%h hi=%h last=%b", lo, hi, last));
                return;
            end
            w = expected_words.pop_front();
            if (w.lo != lo || w.hi != hi || w.last != last)
                flag($sformatf("word mismatch: expected lo=%h hi=%h last=%b, got lo=%h hi=%h last=%b",
                               w.lo, w.hi, w.last, lo, hi, last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 min_time_we;
    logic [MTIME_W-1:0]   min_time_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    packet_predictor pkt_pred = new();

    // which sample slots the stimulus has written, so no packet reads an unwritten slot
    bit [SPIKE_LEN-1:0] filled [2][CHANNELS];
    bit [CHAN_W-1:0]    chan_pool [POOL_SIZE];

    bit tx_idle_on;
    bit rx_idle_on;
    bit pressure_armed;
    bit hold_req;
    int beats_sent;
    int settings_written;
    int cycle_count;

    spike_waveform_packetizer #(
        .CHANNELS  (CHANNELS),
        .SPIKE_LEN (SPIKE_LEN)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_time_we    (min_time_we),
        .min_time_wdata (min_time_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog: a run that never drains ends here
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // output side: every accepted master beat is checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pkt_pred.check_word(m_tdata[HALF_W-1:0], m_tdata[M_TDATA_W-1:HALF_W], m_tlast);
    end

    // receiver: random ready bursts, plus one long hold-off on request
    initial
    begin : receiver
        int burst;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long stall counted here while the sender keeps offering beats
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, GAP_MAX);
                m_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic spike_beat_t mk_beat(bit [CHAN_W-1:0] chan, bit [GROUP_W-1:0] grp,
                                            bit bank, bit [SIDX_W-1:0] sidx,
                                            bit [HALF_W-1:0] lo, bit [HALF_W-1:0] hi,
                                            bit finish, bit [TS_W-1:0] ts);
        spike_beat_t b;
        b.chan   = chan;
        b.grp    = grp;
        b.bank   = bank;
        b.sidx   = sidx;
        b.lo     = lo;
        b.hi     = hi;
        b.finish = finish;
        b.ts     = ts;
        return b;
    endfunction

    // timestamp mix: wrap extremes, values around the threshold, negatives, random
    function automatic bit [TS_W-1:0] pick_ts();
        bit [TS_W-1:0] near;
        near = {{(TS_W-MTIME_W){1'b0}}, pkt_pred.min_time};
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;   // t wraps to the most positive value
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 1);
            3:       return near + 32'd1;    // t equal to min_time, no packet
            4:       return near + 32'd2;    // t just above min_time
            5:       return $urandom | 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // drive one slave beat and wait for its handshake, then maybe leave a gap
    task automatic drive_beat(input spike_beat_t b);
        bit [S_TDATA_W-1:0] data;
        int                 gap;
        if (b.chan < CHANNELS && b.sidx < SPIKE_LEN)
            filled[b.bank][b.chan][b.sidx] = 1'b1;
        // a packet over a half-written waveform would read unwritten slots
        if (b.finish && b.chan < CHANNELS && filled[b.bank][b.chan] != '1
            && pkt_pred.would_emit(b.ts))
            b.ts = TS_W'($urandom_range(0, pkt_pred.min_time + 1));
        // the long output stall starts with a packet so the block backs up
        if (pressure_armed && b.finish && pkt_pred.would_emit(b.ts))
        begin
            hold_req       = 1'b1;
            pressure_armed = 1'b0;
        end
        data                           = '0;
        data[S_CHAN_LSB  +: CHAN_W]    = b.chan;
        data[S_GROUP_LSB +: GROUP_W]   = b.grp;
        data[S_SIDX_LSB  +: SIDX_W]    = b.sidx;
        data[S_LOW_LSB   +: HALF_W]    = b.lo;
        data[S_HIGH_LSB  +: HALF_W]    = b.hi;
        data[S_TS_LSB    +: TS_W]      = b.ts;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= b.bank;
        s_tlast  <= b.finish;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pkt_pred.take_beat(b);
        beats_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, GAP_MAX);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender stops and waits for every queued word, then the block's latency
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pkt_pred.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic write_min_time(input bit [MTIME_W-1:0] value);
        @(negedge clk);
        min_time_we    <= 1'b1;
        min_time_wdata <= value;
        @(negedge clk);
        min_time_we    <= 1'b0;
        pkt_pred.min_time = value;
        settings_written++;
    endtask

    // well-formed spike: samples in shuffled order, finishing beat last
    task automatic run_spike();
        int              order [SPIKE_LEN];
        int              k;
        int              r;
        int              tmp;
        int              cnt;
        int              sel;
        bit [CHAN_W-1:0] ch;
        bit              bk;
        bit [GROUP_W-1:0] gp;
        spike_beat_t     b;
        sel = $urandom_range(0, 19);
        if (sel < 17)
            ch = chan_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (sel < 19)
            ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        else
            ch = CHAN_W'($urandom_range(CHANNELS, 255));
        bk = 1'($urandom_range(0, 1));
        gp = GROUP_W'($urandom_range(0, 255));
        for (k = 0; k < SPIKE_LEN; k++)
            order[k] = k;
        for (k = SPIKE_LEN - 1; k > 0; k--)
        begin
            r        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[r];
            order[r] = tmp;
        end
        // a waveform already complete can be refreshed in part
        if (ch >= CHANNELS || filled[bk][ch] == '1)
            cnt = $urandom_range(1, SPIKE_LEN);
        else
            cnt = SPIKE_LEN;
        for (k = 0; k < cnt; k++)
        begin
            b = mk_beat(ch, gp, bk, SIDX_W'(order[k]), {$urandom, $urandom},
                        {$urandom, $urandom}, k == cnt - 1, 32'd0);
            b.ts = b.finish ? pick_ts() : $urandom;
            drive_beat(b);
        end
    endtask

    // noise: any channel and index, including the ones the block drops
    task automatic noise_burst();
        int          n;
        int          k;
        spike_beat_t b;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            b = mk_beat(CHAN_W'($urandom_range(0, 255)), GROUP_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), SIDX_W'($urandom_range(0, 63)),
                        {$urandom, $urandom}, {$urandom, $urandom},
                        $urandom_range(0, 3) == 0, pick_ts());
            drive_beat(b);
        end
    endtask

    initial
    begin : stimulus
        bit [MTIME_W-1:0] settings_list [PHASES];
        int               k;
        int               start;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        s_tlast          = 1'b0;
        min_time_we      = 1'b0;
        min_time_wdata   = '0;
        rst_n            = 1'b0;
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        pressure_armed   = 1'b0;
        hold_req         = 1'b0;
        beats_sent       = 0;
        settings_written = 0;
        chan_pool[0]     = '0;
        chan_pool[1]     = CHAN_W'(CHANNELS - 1);
        for (k = 2; k < POOL_SIZE; k++)
            chan_pool[k] = CHAN_W'($urandom_range(1, CHANNELS - 2));
        settings_list[0] = 16'd0;
        settings_list[1] = 16'hffff;
        settings_list[2] = MTIME_W'($urandom_range(0, 16'hffff));
        settings_list[3] = MIN_TIME_RESET;
        settings_list[4] = MTIME_W'($urandom_range(0, 16'hffff));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_min_time(MIN_TIME_RESET);

        // directed: out-of-range channels give zero-sample packets
        drive_beat(mk_beat(8'd255, 8'd255, 1'b1, 6'd63, '1, '1, 1'b1, 32'h8000_0000));
        drive_beat(mk_beat(8'd160, 8'd0, 1'b0, 6'd0, '0, '0, 1'b1, 32'h7fff_ffff));
        // t of minus one stays below any threshold
        drive_beat(mk_beat(8'd200, 8'h5a, 1'b1, 6'd5, '1, '0, 1'b1, 32'd0));
        // threshold edge: t equal to min_time, then one above
        drive_beat(mk_beat(8'd170, 8'd1, 1'b0, 6'd7, '0, '1, 1'b1, 32'd11));
        drive_beat(mk_beat(8'd170, 8'd2, 1'b0, 6'd7, '0, '1, 1'b1, 32'd12));
        drive_beat(mk_beat(8'd0, 8'd0, 1'b0, 6'd0, '0, '0, 1'b0, 32'd0));
        // most negative t, no packet
        drive_beat(mk_beat(8'd0, 8'd255, 1'b1, 6'd31, '1, '1, 1'b1, 32'h8000_0001));
        drive_beat(mk_beat(8'd159, 8'd128, 1'b1, 6'd31, '1, '1, 1'b0, 32'hffff_ffff));
        // index past the waveform end is dropped
        drive_beat(mk_beat(8'd159, 8'd3, 1'b0, 6'd32, {$urandom, $urandom}, '1, 1'b1, 32'd1));
        drive_beat(mk_beat(8'd159, 8'd3, 1'b1, 6'd63, '1, '0, 1'b0, 32'd0));
        drive_beat(mk_beat(8'd255, 8'd0, 1'b0, 6'd31, '1, '1, 1'b1, 32'hffff_fffe));
        drive_beat(mk_beat(8'd161, 8'h80, 1'b1, 6'd0, '0, '0, 1'b1, 32'd13));
        wait_idle();

        // random phases, one min_time setting each; the last phase runs without idling
        for (k = 0; k < PHASES; k++)
        begin
            write_min_time(settings_list[k]);
            tx_idle_on     = (k < PHASES - 1);
            rx_idle_on     = (k < PHASES - 1);
            pressure_armed = (k == 1 || k == 3);
            start          = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
            begin
                if ($urandom_range(0, 9) < 8)
                    run_spike();
                else
                    noise_burst();
            end
            wait_idle();
        end

        if (pkt_pred.expected_words.size() != 0)
            pkt_pred.flag($sformatf("%0d packet words never arrived",
                                    pkt_pred.expected_words.size()));
        $display("covered %0d input beats, %0d packets, %0d output words, %0d min_time settings",
                 beats_sent, pkt_pred.packets, pkt_pred.words_seen, settings_written);
        $display("with random gaps on both sides, long output stalls and %0d failures",
                 pkt_pred.failures);
        if (pkt_pred.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ spike_waveform_packetizer.f @@
sv/swp_pkg.sv
sv/swp_ram.sv
sv/swp_ctrl.sv
sv/swp_dp.sv
sv/spike_waveform_packetizer.sv
sv/swp_checker.sv
bench/spike_waveform_packetizer_test.sv
